// ----- rtl/bpsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bpsd_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int MAX_IMAGE_DIM  = 65535;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;
    localparam logic [1:0] KIND_TRUNC  = 2'd3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic push_a;
        logic push_b;
    } t_push;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  room;
    } t_fifo_status;

endpackage
`default_nettype wire

// ----- rtl/bpsd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpsd_decode #(
    parameter int COORD_BITS = bpsd_pkg::COORD_BITS_DEF,
    parameter int RES_W      = 2 + 16 + 2 * COORD_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_byte_value,
    input  wire logic                 i_last_byte,
    output bpsd_pkg::t_push           o_push,
    output logic      [RES_W-1:0]     o_res_a,
    output logic      [RES_W-1:0]     o_res_b
);

    localparam int CW = COORD_BITS + 1;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_SKIP   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_DRAIN  = 2'd3;

    localparam logic [1:0] CFG_SCREEN_W = 2'd0;
    localparam logic [1:0] CFG_SCREEN_H = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd3;

    localparam logic [31:0] OFF_SIG      = 32'd1;
    localparam logic [31:0] OFF_DATA     = 32'd13;
    localparam logic [31:0] OFF_HDR_SIZE = 32'd17;
    localparam logic [31:0] OFF_WIDTH    = 32'd21;
    localparam logic [31:0] OFF_HEIGHT   = 32'd25;
    localparam logic [31:0] OFF_PLANES   = 32'd27;
    localparam logic [31:0] OFF_DEPTH    = 32'd29;
    localparam logic [31:0] OFF_COMPRESS = 32'd33;
    localparam logic [31:0] DATA_MIN     = 32'd34;

    localparam logic [15:0] SIGNATURE    = 16'h4D42;
    localparam logic [31:0] HDR_SIZE_MIN = 32'd40;
    localparam logic [15:0] DEPTH_24     = 16'd24;
    localparam logic [15:0] DEPTH_16     = 16'd16;
    localparam logic [31:0] DIM_MAX      = 32'(bpsd_pkg::MAX_IMAGE_DIM);

    // configuration
    logic [12:0] r_scr_w, r_scr_h;
    logic [15:0] r_org_x, r_org_y;

    // parser state
    logic [1:0]    r_phase, n_phase;
    logic [31:0]   r_offset, n_offset;
    logic [31:0]   r_shift, n_shift;
    logic [31:0]   r_data_start, n_data_start;
    logic [15:0]   r_img_w, n_img_w;
    logic [15:0]   r_img_h, n_img_h;
    logic          r_top_down, n_top_down;
    logic          r_three, n_three;
    logic [CW-1:0] r_clip_w, n_clip_w;
    logic [CW-1:0] r_clip_h, n_clip_h;
    logic [17:0]   r_raw_len, n_raw_len;
    logic [17:0]   r_pad_len, n_pad_len;
    logic [15:0]   r_keep_start, n_keep_start;
    logic [17:0]   r_bir, n_bir;
    logic [15:0]   r_row, n_row;
    logic [15:0]   r_col, n_col;
    logic [1:0]    r_pbi, n_pbi;
    logic [15:0]   r_low, n_low;

    // per-byte decode
    logic [31:0] w_v, w_neg;
    logic [15:0] w_h16;
    logic        w_bad;
    logic        w_pix, w_end, w_trunc;
    logic [1:0]  w_end_kind;
    logic [15:0] w_color, w_out_row;
    logic [17:0] w_raw, w_bir_inc;
    logic [16:0] w_clip_h_ext, w_clip_w_ext;
    logic        w_kept, w_last_row;
    logic [1:0]  w_pbi_last;

    function automatic logic [CW-1:0] clip_extent(input logic [15:0] image,
                                                  input logic [12:0] screen,
                                                  input logic [15:0] origin);
        logic [15:0] o, scr, avail, e;
        logic [16:0] e17, cap17, res;
        o     = origin[15] ? 16'd0 : origin;
        scr   = {3'd0, screen};
        avail = (scr > o) ? scr - o : 16'd0;
        e     = (image < avail) ? image : avail;
        e17   = {1'b0, e};
        cap17 = 17'd1 << COORD_BITS;
        res   = (e17 < cap17) ? e17 : cap17;
        return res[CW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= 13'd320;
            r_scr_h <= 13'd240;
            r_org_x <= 16'd0;
            r_org_y <= 16'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_W: r_scr_w <= i_cfg_data[12:0];
                CFG_SCREEN_H: r_scr_h <= i_cfg_data[12:0];
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_offset     = r_offset;
        n_shift      = r_shift;
        n_data_start = r_data_start;
        n_img_w      = r_img_w;
        n_img_h      = r_img_h;
        n_top_down   = r_top_down;
        n_three      = r_three;
        n_clip_w     = r_clip_w;
        n_clip_h     = r_clip_h;
        n_raw_len    = r_raw_len;
        n_pad_len    = r_pad_len;
        n_keep_start = r_keep_start;
        n_bir        = r_bir;
        n_row        = r_row;
        n_col        = r_col;
        n_pbi        = r_pbi;
        n_low        = r_low;

        w_bad      = 1'b0;
        w_pix      = 1'b0;
        w_end      = 1'b0;
        w_trunc    = 1'b0;
        w_end_kind = bpsd_pkg::KIND_DONE;

        w_v   = {i_byte_value, r_shift[31:8]};
        w_h16 = w_v[31:16];
        w_neg = w_v[31] ? (32'd0 - w_v) : w_v;

        w_raw = r_three ? ({2'd0, r_img_w} + {1'b0, r_img_w, 1'b0})
                        : {1'b0, r_img_w, 1'b0};

        w_clip_h_ext = 17'(r_clip_h);
        w_clip_w_ext = 17'(r_clip_w);
        w_kept     = r_top_down ? ({1'b0, r_row} < w_clip_h_ext) : (r_row >= r_keep_start);
        w_out_row  = r_top_down ? r_row : (r_img_h - 16'd1 - r_row);
        w_last_row = r_top_down ? ({1'b0, r_row} == w_clip_h_ext - 17'd1)
                                : (r_row == r_img_h - 16'd1);
        w_pbi_last = r_three ? 2'd2 : 2'd1;
        w_color    = r_three ? {i_byte_value[7:3], r_low[15:10], r_low[7:3]}
                             : {i_byte_value, r_low[7:0]};
        w_bir_inc  = r_bir + 18'd1;

        case (r_phase)
            PH_HEADER: begin
                n_shift  = w_v;
                n_offset = r_offset + 32'd1;
                if (r_offset == OFF_SIG) begin
                    w_bad = (w_h16 != SIGNATURE);
                end else if (r_offset == OFF_DATA) begin
                    n_data_start = w_v;
                    w_bad = (w_v < DATA_MIN);
                end else if (r_offset == OFF_HDR_SIZE) begin
                    w_bad = (w_v < HDR_SIZE_MIN);
                end else if (r_offset == OFF_WIDTH) begin
                    if (w_v == 32'd0 || w_v[31] || w_v > DIM_MAX) w_bad = 1'b1;
                    else n_img_w = w_v[15:0];
                end else if (r_offset == OFF_HEIGHT) begin
                    n_top_down = w_v[31];
                    if (w_v == 32'd0 || w_neg > DIM_MAX) w_bad = 1'b1;
                    else n_img_h = w_neg[15:0];
                end else if (r_offset == OFF_PLANES) begin
                    w_bad = (w_h16 != 16'd1);
                end else if (r_offset == OFF_DEPTH) begin
                    if (w_h16 == DEPTH_24) n_three = 1'b1;
                    else if (w_h16 == DEPTH_16) n_three = 1'b0;
                    else w_bad = 1'b1;
                end else if (r_offset == OFF_COMPRESS) begin
                    if (w_v != 32'd0) begin
                        w_bad = 1'b1;
                    end else begin
                        n_clip_w = clip_extent(r_img_w, r_scr_w, r_org_x);
                        n_clip_h = clip_extent(r_img_h, r_scr_h, r_org_y);
                        if (n_clip_w == '0 || n_clip_h == '0) begin
                            w_bad = 1'b1;
                        end else begin
                            n_raw_len    = w_raw;
                            n_pad_len    = (w_raw + 18'd3) & ~18'd3;
                            n_keep_start = r_img_h - 16'(n_clip_h);
                            n_phase      = (r_data_start == DATA_MIN) ? PH_DATA : PH_SKIP;
                        end
                    end
                end
                if (w_bad) begin
                    w_end      = 1'b1;
                    w_end_kind = bpsd_pkg::KIND_REJECT;
                    n_phase    = PH_DRAIN;
                end
            end
            PH_SKIP: begin
                if (r_offset + 32'd1 == r_data_start) n_phase = PH_DATA;
                n_offset = r_offset + 32'd1;
            end
            PH_DATA: begin
                if (r_bir < r_raw_len) begin
                    if (r_pbi == w_pbi_last) begin
                        w_pix = w_kept && ({1'b0, r_col} < w_clip_w_ext);
                        n_pbi = 2'd0;
                        n_col = r_col + 16'd1;
                    end else begin
                        if (r_pbi == 2'd0) n_low = {8'd0, i_byte_value};
                        else n_low = {i_byte_value, r_low[7:0]};
                        n_pbi = r_pbi + 2'd1;
                    end
                end
                n_bir = w_bir_inc;
                if (w_bir_inc >= r_pad_len) begin
                    n_bir = 18'd0;
                    n_pbi = 2'd0;
                    n_col = 16'd0;
                    if (w_last_row) begin
                        w_end   = 1'b1;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_row = r_row + 16'd1;
                    end
                end
            end
            default: ;
        endcase

        if (i_last_byte) begin
            w_trunc      = (n_phase != PH_DRAIN);
            // rearm for the next file
            n_phase      = PH_HEADER;
            n_offset     = 32'd0;
            n_shift      = 32'd0;
            n_data_start = 32'd0;
            n_img_w      = 16'd0;
            n_img_h      = 16'd0;
            n_top_down   = 1'b0;
            n_three      = 1'b0;
            n_clip_w     = '0;
            n_clip_h     = '0;
            n_raw_len    = 18'd0;
            n_pad_len    = 18'd0;
            n_keep_start = 16'd0;
            n_bir        = 18'd0;
            n_row        = 16'd0;
            n_col        = 16'd0;
            n_pbi        = 2'd0;
            n_low        = 16'd0;
        end
    end

    // results in order: pixel, then end of file or truncation
    always_comb begin
        o_res_a = '0;
        o_res_b = '0;
        if (w_pix) begin
            o_res_a = {bpsd_pkg::KIND_PIXEL, w_color, r_col[COORD_BITS-1:0],
                       w_out_row[COORD_BITS-1:0]};
            if (w_end) o_res_b = {w_end_kind, (RES_W-2)'(0)};
            else o_res_b = {bpsd_pkg::KIND_TRUNC, (RES_W-2)'(0)};
        end else if (w_end) begin
            o_res_a = {w_end_kind, (RES_W-2)'(0)};
        end else begin
            o_res_a = {bpsd_pkg::KIND_TRUNC, (RES_W-2)'(0)};
        end
        o_push.push_a = i_accept && (w_pix || w_end || w_trunc);
        o_push.push_b = i_accept && w_pix && (w_end || w_trunc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_offset     <= 32'd0;
            r_shift      <= 32'd0;
            r_data_start <= 32'd0;
            r_img_w      <= 16'd0;
            r_img_h      <= 16'd0;
            r_top_down   <= 1'b0;
            r_three      <= 1'b0;
            r_clip_w     <= '0;
            r_clip_h     <= '0;
            r_raw_len    <= 18'd0;
            r_pad_len    <= 18'd0;
            r_keep_start <= 16'd0;
            r_bir        <= 18'd0;
            r_row        <= 16'd0;
            r_col        <= 16'd0;
            r_pbi        <= 2'd0;
            r_low        <= 16'd0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_offset     <= n_offset;
            r_shift      <= n_shift;
            r_data_start <= n_data_start;
            r_img_w      <= n_img_w;
            r_img_h      <= n_img_h;
            r_top_down   <= n_top_down;
            r_three      <= n_three;
            r_clip_w     <= n_clip_w;
            r_clip_h     <= n_clip_h;
            r_raw_len    <= n_raw_len;
            r_pad_len    <= n_pad_len;
            r_keep_start <= n_keep_start;
            r_bir        <= n_bir;
            r_row        <= n_row;
            r_col        <= n_col;
            r_pbi        <= n_pbi;
            r_low        <= n_low;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bpsd_result_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module bpsd_result_fifo #(
    parameter int RES_W = 2 + 16 + 2 * bpsd_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire bpsd_pkg::t_push       i_push,
    input  wire logic      [RES_W-1:0] i_res_a,
    input  wire logic      [RES_W-1:0] i_res_b,
    output bpsd_pkg::t_fifo_status     o_status,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic           [RES_W-1:0] o_res
);

    localparam int DEPTH = bpsd_pkg::FIFO_DEPTH;
    localparam int CNTW  = bpsd_pkg::FIFO_CNT_W;

    // entry 0 is the head; entries move down one place on each pop
    logic [RES_W-1:0] r_q [DEPTH];
    logic [RES_W-1:0] n_q [DEPTH];
    logic [CNTW-1:0]  r_count, n_count;
    logic [CNTW-1:0]  w_base;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && !i_stall;
    assign o_res   = r_q[0];
    assign w_base  = r_count - CNTW'(w_pop);

    // room for the two results a single transaction can produce
    assign o_status.count = r_count;
    assign o_status.room  = (r_count <= CNTW'(bpsd_pkg::FIFO_DEPTH - 2));

    always_comb begin
        n_count = r_count + CNTW'(i_push.push_a) + CNTW'(i_push.push_b) - CNTW'(w_pop);
        for (int i = 0; i < DEPTH; i++) n_q[i] = r_q[i];
        if (w_pop) begin
            for (int i = 0; i < DEPTH - 1; i++) n_q[i] = r_q[i + 1];
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (i_push.push_a && CNTW'(i) == w_base) n_q[i] = i_res_a;
            if (i_push.push_b && CNTW'(i) == w_base + CNTW'(1)) n_q[i] = i_res_b;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) r_q[i] <= n_q[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bmp_pixel_stream_decoder_top.sv -----
// results: written to the result queue on the byte's transaction and offered from its head
// throughput: one byte per cycle while the result queue has room; parser state updates per accepted byte
// a byte causing two results pushes both together; the 4-entry queue absorbs them
// reset: synchronous active-low; parser rearms to header, config returns to 320x240 at 0,0
`timescale 1ns / 1ps
`default_nettype none
module bmp_pixel_stream_decoder_top #(
    parameter int COORD_BITS = bpsd_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [1:0]            i_cfg_index,
    input  wire logic [15:0]           i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_byte_value,
    input  wire logic                  i_last_byte,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic      [1:0]            o_result_kind,
    output logic      [15:0]           o_pixel_color,
    output logic      [COORD_BITS-1:0] o_pixel_column,
    output logic      [COORD_BITS-1:0] o_pixel_row
);

    localparam int RES_W = 2 + 16 + 2 * COORD_BITS;

    bpsd_pkg::t_push        w_push;
    bpsd_pkg::t_fifo_status w_status;
    logic [RES_W-1:0]       w_res_a, w_res_b, w_res;
    logic                   w_accept;

    assign o_stall  = !w_status.room;
    assign w_accept = i_valid && w_status.room;

    bpsd_decode #(
        .COORD_BITS (COORD_BITS),
        .RES_W      (RES_W)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_byte_value (i_byte_value),
        .i_last_byte  (i_last_byte),
        .o_push       (w_push),
        .o_res_a      (w_res_a),
        .o_res_b      (w_res_b)
    );

    bpsd_result_fifo #(
        .RES_W (RES_W)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_res_a  (w_res_a),
        .i_res_b  (w_res_b),
        .o_status (w_status),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_res    (w_res)
    );

    assign o_result_kind  = w_res[RES_W-1 -: 2];
    assign o_pixel_color  = w_res[2*COORD_BITS +: 16];
    assign o_pixel_column = w_res[COORD_BITS +: COORD_BITS];
    assign o_pixel_row    = w_res[0 +: COORD_BITS];

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.count <= bpsd_pkg::FIFO_CNT_W'(bpsd_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    a_valid_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid == (w_status.count != '0))
        else $error("output valid disagrees with queue fill");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind != bpsd_pkg::KIND_PIXEL) |->
        (o_pixel_color == 16'd0 && o_pixel_column == '0 && o_pixel_row == '0))
        else $error("status result carries pixel data");

    a_two_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push_b |-> (w_push.push_a && w_status.room))
        else $error("second result pushed without room");
`endif

endmodule
`default_nettype wire

// ----- sim/tb_bmp_pixel_stream_decoder_top.sv -----
`timescale 1ns / 1ps
module tb_bmp_pixel_stream_decoder_top;

    localparam int CB = bpsd_pkg::COORD_BITS_DEF;

    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ORIGIN_X      = 2'd2;
    localparam logic [1:0] REG_ORIGIN_Y      = 2'd3;

    localparam logic [15:0] BMP_SIGNATURE    = 16'h4D42;
    localparam int          HEADER_BYTES     = 34;
    localparam int          INFO_SIZE_MIN    = 40;
    localparam logic [15:0] DEPTH_24         = 16'd24;
    localparam logic [15:0] DEPTH_16         = 16'd16;
    localparam int          COMPRESSION_NONE = 0;

    // offset of the byte that completes each header field
    localparam int OFS_SIGNATURE   = 1;
    localparam int OFS_DATA_OFFSET = 13;
    localparam int OFS_INFO_SIZE   = 17;
    localparam int OFS_WIDTH       = 21;
    localparam int OFS_HEIGHT      = 25;
    localparam int OFS_PLANES      = 27;
    localparam int OFS_DEPTH       = 29;
    localparam int OFS_COMPRESSION = 33;

    localparam int RANDOM_BYTES   = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int IDLE_PCT       = 38;

    typedef enum logic [1:0] {
        ST_HEADER,
        ST_SKIP,
        ST_DATA,
        ST_DRAIN
    } t_decode_state;

    typedef struct packed {
        logic [1:0]    kind;
        logic [15:0]   color;
        logic [CB-1:0] col;
        logic [CB-1:0] row;
    } t_pixel_result;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [15:0]   i_cfg_data;
    logic          i_valid;
    logic          o_stall;
    logic [7:0]    i_byte_value;
    logic          i_last_byte;
    logic          o_valid;
    logic          i_stall;
    logic [1:0]    o_result_kind;
    logic [15:0]   o_pixel_color;
    logic [CB-1:0] o_pixel_column;
    logic [CB-1:0] o_pixel_row;

    bmp_pixel_stream_decoder_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_kind  (o_result_kind),
        .o_pixel_color  (o_pixel_color),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row)
    );

    // decoder model state
    logic [12:0]   screen_w, screen_h;
    logic [15:0]   org_x, org_y;
    t_decode_state phase;
    logic [31:0]   hdr_pos, field_bytes, data_ofs;
    logic [31:0]   img_w, img_h;
    logic          top_down, rgb24;
    logic [31:0]   win_w, win_h, row_len, row_pos, src_row;
    logic [1:0]    pix_idx;
    logic [15:0]   pix_lo;

    t_pixel_result expected_results[$];
    logic [7:0]    file_bytes[$];

    int fail_count    = 0;
    int sent_bytes    = 0;
    int tx_idle_pct   = IDLE_PCT;
    int rx_idle_pct   = IDLE_PCT;
    int rx_hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [31:0] clip_span(input logic [31:0] img, input logic [12:0] scr,
                                              input logic [15:0] org);
        logic [31:0] o, avail, e;
        o = org[15] ? 32'd0 : {16'd0, org};
        avail = ({19'd0, scr} > o) ? {19'd0, scr} - o : 32'd0;
        e = (img < avail) ? img : avail;
        return (e < (32'd1 << CB)) ? e : (32'd1 << CB);
    endfunction

    function automatic void rearm_decoder();
        phase = ST_HEADER;
        hdr_pos = 32'd0; field_bytes = 32'd0; data_ofs = 32'd0;
        img_w = 32'd0; img_h = 32'd0; top_down = 1'b0; rgb24 = 1'b0;
        win_w = 32'd0; win_h = 32'd0; row_len = 32'd0; row_pos = 32'd0; src_row = 32'd0;
        pix_idx = 2'd0; pix_lo = 16'd0;
    endfunction

    function automatic void expect_result(input logic [1:0] kind, input logic [15:0] color,
                                          input logic [31:0] col, input logic [31:0] row);
        t_pixel_result r;
        r.kind = kind;
        r.color = color;
        r.col = col[CB-1:0];
        r.row = row[CB-1:0];
        expected_results.push_back(r);
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic last);
        logic        bad, kept, last_row;
        logic [31:0] v, a, bpp, col, out_row;
        logic [15:0] h16, color;
        bad = 1'b0;
        case (phase)
            ST_HEADER: begin
                field_bytes = {b, field_bytes[31:8]};
                v = field_bytes;
                h16 = v[31:16];
                case (hdr_pos)
                    OFS_SIGNATURE: bad = (h16 != BMP_SIGNATURE);
                    OFS_DATA_OFFSET: begin
                        data_ofs = v;
                        bad = (v < HEADER_BYTES);
                    end
                    OFS_INFO_SIZE: bad = (v < INFO_SIZE_MIN);
                    OFS_WIDTH: begin
                        if (v == 0 || v[31] || v > bpsd_pkg::MAX_IMAGE_DIM) bad = 1'b1;
                        else img_w = v;
                    end
                    OFS_HEIGHT: begin
                        top_down = v[31];
                        a = top_down ? (32'd0 - v) : v;
                        if (v == 0 || a > bpsd_pkg::MAX_IMAGE_DIM) bad = 1'b1;
                        else img_h = a;
                    end
                    OFS_PLANES: bad = (h16 != 16'd1);
                    OFS_DEPTH: begin
                        if (h16 == DEPTH_24) rgb24 = 1'b1;
                        else if (h16 == DEPTH_16) rgb24 = 1'b0;
                        else bad = 1'b1;
                    end
                    OFS_COMPRESSION: begin
                        if (v != COMPRESSION_NONE) begin
                            bad = 1'b1;
                        end else begin
                            win_w = clip_span(img_w, screen_w, org_x);
                            win_h = clip_span(img_h, screen_h, org_y);
                            if (win_w == 0 || win_h == 0) begin
                                bad = 1'b1;
                            end else begin
                                row_len = (img_w * (rgb24 ? 3 : 2) + 3) & ~32'd3;
                                phase = (data_ofs == HEADER_BYTES) ? ST_DATA : ST_SKIP;
                            end
                        end
                    end
                    default: ;
                endcase
                hdr_pos = hdr_pos + 1;
                if (bad) begin
                    expect_result(bpsd_pkg::KIND_REJECT, 16'd0, 0, 0);
                    phase = ST_DRAIN;
                end
            end
            ST_SKIP: begin
                if (hdr_pos + 1 == data_ofs) phase = ST_DATA;
                hdr_pos = hdr_pos + 1;
            end
            ST_DATA: begin
                bpp = rgb24 ? 32'd3 : 32'd2;
                kept = top_down ? (src_row < win_h) : (src_row >= img_h - win_h);
                out_row = top_down ? src_row : img_h - 1 - src_row;
                last_row = top_down ? (src_row == win_h - 1) : (src_row == img_h - 1);
                if (row_pos < img_w * bpp) begin
                    col = row_pos / bpp;
                    if (pix_idx == bpp - 1) begin
                        if (rgb24) color = {b[7:3], pix_lo[15:10], pix_lo[7:3]};
                        else color = {b, pix_lo[7:0]};
                        if (kept && col < win_w) begin
                            expect_result(bpsd_pkg::KIND_PIXEL, color, col, out_row);
                        end
                        pix_idx = 2'd0;
                    end else begin
                        if (pix_idx == 0) pix_lo = {8'd0, b};
                        else pix_lo = {b, pix_lo[7:0]};
                        pix_idx = pix_idx + 2'd1;
                    end
                end
                row_pos = row_pos + 1;
                if (row_pos >= row_len) begin
                    row_pos = 32'd0;
                    pix_idx = 2'd0;
                    if (last_row) begin
                        expect_result(bpsd_pkg::KIND_DONE, 16'd0, 0, 0);
                        phase = ST_DRAIN;
                    end else begin
                        src_row = (src_row + 1) & 32'h0000_FFFF;
                    end
                end
            end
            default: ;
        endcase
        if (last) begin
            if (phase != ST_DRAIN) expect_result(bpsd_pkg::KIND_TRUNC, 16'd0, 0, 0);
            rearm_decoder();
        end
    endfunction

    // input channel
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_byte_value <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        decode_byte(b, last);
        sent_bytes++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_bytes.size(); i++) begin
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_SCREEN_WIDTH:  screen_w = data[12:0];
            REG_SCREEN_HEIGHT: screen_h = data[12:0];
            REG_ORIGIN_X:      org_x = data;
            default:           org_y = data;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_window(input logic [15:0] w, input logic [15:0] h,
                              input logic [15:0] x, input logic [15:0] y);
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
        write_reg(REG_ORIGIN_X, x);
        write_reg(REG_ORIGIN_Y, y);
    endtask

    task automatic append_le(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++) file_bytes.push_back(value[8*i +: 8]);
    endtask

    task automatic add_random_bytes(input int n);
        repeat (n) file_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic start_bmp(input logic [15:0] sig, input logic [31:0] ofs,
                             input logic [31:0] info, input logic [31:0] w,
                             input logic [31:0] h, input logic [15:0] planes,
                             input logic [15:0] depth, input logic [31:0] comp);
        file_bytes.delete();
        append_le(sig, 2);
        append_le($urandom, 4);
        append_le($urandom, 4);
        append_le(ofs, 4);
        append_le(info, 4);
        append_le(w, 4);
        append_le(h, 4);
        append_le(planes, 2);
        append_le(depth, 2);
        append_le(comp, 4);
    endtask

    // negative height gives a top-down image
    task automatic build_image(input int w, input int h, input logic [15:0] depth,
                               input int ofs);
        int rows, padded;
        rows = (h < 0) ? -h : h;
        padded = (w * (depth == DEPTH_24 ? 3 : 2) + 3) & ~3;
        start_bmp(BMP_SIGNATURE, ofs, INFO_SIZE_MIN, w, h, 16'd1, depth, COMPRESSION_NONE);
        add_random_bytes(ofs - HEADER_BYTES);
        add_random_bytes(padded * rows);
    endtask

    task automatic random_config();
        logic [15:0] v[4];
        for (int i = 0; i < 2; i++) begin
            v[i] = ($urandom_range(3) == 0) ? 16'($urandom_range(1, 4096))
                                            : 16'($urandom_range(1, 8));
        end
        for (int i = 2; i < 4; i++) begin
            case ($urandom_range(9))
                7:       v[i] = 16'h8000 | 16'($urandom);
                8, 9:    v[i] = 16'($urandom);
                default: v[i] = 16'($urandom_range(2));
            endcase
        end
        set_window(v[0], v[1], v[2], v[3]);
    endtask

    task automatic random_bmp_file();
        int w, h, roll;
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        if ($urandom_range(1)) h = -h;
        build_image(w, h, $urandom_range(1) ? DEPTH_24 : DEPTH_16,
                    HEADER_BYTES + (($urandom_range(3) == 0) ? $urandom_range(1, 6) : 0));
        roll = $urandom_range(99);
        if (roll >= 65 && roll < 75) begin
            add_random_bytes($urandom_range(1, 6));
        end else if (roll < 87 && roll >= 75) begin
            roll = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > roll) void'(file_bytes.pop_back());
        end else if (roll < 95 && roll >= 87) begin
            file_bytes[$urandom_range(HEADER_BYTES - 1)] = 8'($urandom_range(255));
        end else if (roll >= 95) begin
            file_bytes.delete();
            add_random_bytes($urandom_range(1, 40));
        end
        send_file();
    endtask

    task automatic test_basic_images();
        build_image(3, 2, DEPTH_24, HEADER_BYTES);
        send_file();
        build_image(2, -3, DEPTH_16, HEADER_BYTES + 4);
        send_file();
    endtask

    task automatic test_header_rejects();
        logic [15:0] sig, planes, depth;
        logic [31:0] ofs, info, w, h, comp;
        for (int c = 0; c < 14; c++) begin
            sig = BMP_SIGNATURE; ofs = HEADER_BYTES; info = INFO_SIZE_MIN;
            w = 2; h = 2; planes = 16'd1; depth = DEPTH_24; comp = COMPRESSION_NONE;
            case (c)
                0:  sig = 16'h424D;
                1:  ofs = HEADER_BYTES - 1;
                2:  info = INFO_SIZE_MIN - 1;
                3:  w = 0;
                4:  w = 32'hFFFF_FFFF;
                5:  w = 32'h0001_0000;
                6:  h = 0;
                7:  h = 32'h8000_0000;
                8:  h = 32'hFFFF_0000;
                9:  h = 32'h0001_0000;
                10: planes = 16'd0;
                11: depth = 16'd32;
                12: comp = 1;
                default: comp = 32'h8000_0000;
            endcase
            start_bmp(sig, ofs, info, w, h, planes, depth, comp);
            add_random_bytes($urandom_range(3));
            send_file();
        end
    endtask

    task automatic test_header_extremes();
        // widest, tallest accepted sizes cut short in pixel data; then the largest info size
        start_bmp(BMP_SIGNATURE, HEADER_BYTES, INFO_SIZE_MIN, bpsd_pkg::MAX_IMAGE_DIM, 1,
                  16'd1, DEPTH_24, COMPRESSION_NONE);
        add_random_bytes(10);
        send_file();
        start_bmp(BMP_SIGNATURE, HEADER_BYTES, INFO_SIZE_MIN, 1, 32'hFFFF_0001, 16'd1,
                  DEPTH_16, COMPRESSION_NONE);
        add_random_bytes(6);
        send_file();
        start_bmp(BMP_SIGNATURE, HEADER_BYTES + 6, 32'hFFFF_FFFF, 1, 1, 16'd1,
                  DEPTH_16, COMPRESSION_NONE);
        add_random_bytes(10);
        send_file();
        // ends while skipping to the data offset
        start_bmp(BMP_SIGNATURE, 300, INFO_SIZE_MIN, 1, 1, 16'd1, DEPTH_16, COMPRESSION_NONE);
        add_random_bytes(5);
        send_file();
        // ends inside the header, then a one-byte file
        build_image(2, 2, DEPTH_24, HEADER_BYTES);
        while (file_bytes.size() > 10) void'(file_bytes.pop_back());
        send_file();
        file_bytes.delete();
        file_bytes.push_back(8'h42);
        send_file();
    endtask

    task automatic test_padding_and_depths();
        build_image(1, 2, DEPTH_16, HEADER_BYTES);
        send_file();
        // unpadded rows: last pixel and finish on the same byte
        build_image(2, 2, DEPTH_16, HEADER_BYTES);
        send_file();
        build_image(4, 1, DEPTH_24, HEADER_BYTES);
        send_file();
        build_image(1, -2, DEPTH_24, HEADER_BYTES);
        send_file();
        // trailing bytes after the finish are ignored
        build_image(5, 2, DEPTH_24, HEADER_BYTES + 1);
        add_random_bytes(5);
        send_file();
        // last byte completes a pixel before the image is done
        build_image(2, 2, DEPTH_16, HEADER_BYTES);
        void'(file_bytes.pop_back());
        void'(file_bytes.pop_back());
        send_file();
    endtask

    task automatic test_clip_window();
        set_window(16'd1, 16'd1, 16'd0, 16'd0);
        build_image(3, 3, DEPTH_24, HEADER_BYTES);
        send_file();
        // negative origin clips as zero
        set_window(16'd4, 16'd2, 16'h8000, 16'hFFFF);
        build_image(6, -5, DEPTH_16, HEADER_BYTES);
        send_file();
        set_window(16'd4, 16'd2, 16'd3, 16'd1);
        build_image(6, 5, DEPTH_16, HEADER_BYTES);
        send_file();
        // origin at or past the screen edge empties the window; one short leaves one pixel
        write_reg(REG_ORIGIN_X, 16'd4);
        build_image(2, 2, DEPTH_24, HEADER_BYTES);
        send_file();
        write_reg(REG_ORIGIN_X, 16'h7FFF);
        build_image(2, 2, DEPTH_24, HEADER_BYTES);
        send_file();
        set_window(16'd4, 16'd2, 16'd0, 16'h7FFF);
        build_image(2, 2, DEPTH_24, HEADER_BYTES);
        send_file();
        set_window(16'd4096, 16'd4096, 16'd4095, 16'd4095);
        build_image(2, 2, DEPTH_24, HEADER_BYTES);
        send_file();
        set_window(16'd320, 16'd240, 16'd0, 16'd0);
    endtask

    task automatic test_full_coordinates();
        // bottom-up image as tall as the window: first rows land on the bottom window rows
        set_window(16'd4096, 16'd4096, 16'd0, 16'd0);
        start_bmp(BMP_SIGNATURE, HEADER_BYTES, INFO_SIZE_MIN, 1, 4096, 16'd1,
                  DEPTH_16, COMPRESSION_NONE);
        add_random_bytes(12);
        send_file();
        set_window(16'd320, 16'd240, 16'd0, 16'd0);
    endtask

    task automatic test_back_pressure();
        rx_hold_cycles = 150;
        build_image(8, -6, DEPTH_24, HEADER_BYTES + 2);
        send_file();
    endtask

    task automatic test_no_idle();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (4) random_bmp_file();
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_files();
        int start;
        start = sent_bytes;
        while (sent_bytes - start < RANDOM_BYTES) begin
            if ($urandom_range(3) == 0) random_config();
            random_bmp_file();
        end
    endtask

    // output channel stall
    initial begin : result_receiver
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_stall <= 1'b1;
                rx_hold_cycles--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin : result_checker
        t_pixel_result want, got;
        int reported;
        reported = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got = {o_result_kind, o_pixel_color, o_pixel_column, o_pixel_row};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (reported < 10) begin
                        $display("unexpected transaction: kind %0d color %h col %0d row %0d",
                                 got.kind, got.color, got.col, got.row);
                        reported++;
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (reported < 10) begin
                            $display("mismatch: expected kind %0d color %h col %0d row %0d",
                                     want.kind, want.color, want.col, want.row);
                            $display("          actual   kind %0d color %h col %0d row %0d",
                                     got.kind, got.color, got.col, got.row);
                            reported++;
                        end
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_SCREEN_WIDTH;
        i_cfg_data <= 16'd0;
        i_valid <= 1'b0;
        i_byte_value <= 8'd0;
        i_last_byte <= 1'b0;
        screen_w = 13'd320;
        screen_h = 13'd240;
        org_x = 16'd0;
        org_y = 16'd0;
        rearm_decoder();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_images();
        test_header_rejects();
        test_header_extremes();
        test_padding_and_depths();
        test_clip_window();
        test_full_coordinates();
        test_back_pressure();
        test_no_idle();
        test_random_files();

        wait_drained();
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/bpsd_pkg.sv
rtl/bpsd_decode.sv
rtl/bpsd_result_fifo.sv
rtl/bmp_pixel_stream_decoder_top.sv
sim/tb_bmp_pixel_stream_decoder_top.sv
